// ----- sv/txc_pkg.sv -----
// shared field widths and command codes for the text console writer
`default_nettype none
package txc_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned LIN_W  = ROW_W + COL_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

endpackage
`default_nettype wire

// ----- sv/text_console_writer_top.sv -----
// text console writer: cell store, cursor, scroll sequencer and result port
//
//   channel   direction   handshake            fields
//   command   in          start / busy         command_i character_i column_i row_i
//   result    out         done_o strobe        cell_word_o cursor_position_o scrolled_o
//   config    in          cfg_we_i             cfg_wdata_i (attribute byte)
//
// put, set and unused commands strobe the result in the following cycle;
// busy stays low unless a put scrolls, so these can follow back to back.
// read holds busy in ST_READ (the memory read port); the result is registered
// after that state. a scrolling put holds busy through ST_SCROLL and ST_DRAIN:
// the single read and write port of the cell memory copy one cell per cycle.
// after reset busy stays high while the memory is cleared one cell per cycle.
// results cannot be held off by the receiver.
`default_nettype none
module text_console_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [txc_pkg::CMD_W-1:0]    command_i,
  input  wire logic [txc_pkg::CHAR_W-1:0]   character_i,
  input  wire logic [txc_pkg::COL_W-1:0]    column_i,
  input  wire logic [txc_pkg::ROW_W-1:0]    row_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [txc_pkg::ATTR_W-1:0]   cfg_wdata_i,
  output logic                              done_o,
  output logic      [txc_pkg::CELL_W-1:0]   cell_word_o,
  output logic      [txc_pkg::POS_W-1:0]    cursor_position_o,
  output logic                              scrolled_o
);
  import txc_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  localparam logic [AW-1:0]    LAST_IDX = AW'(CELLS - 1);
  localparam logic [AW-1:0]    COPY_N   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0]    ROW_STEP = AW'(COLUMNS);
  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN
  } state_e;

  function automatic logic [LIN_W-1:0] lin_of(input logic [ROW_W-1:0] r,
                                              input logic [COL_W-1:0] c);
    lin_of = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
  endfunction

  state_e              state_q, state_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ATTR_W-1:0]   attr_q;
  logic                done_q, done_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                scr_q, scr_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_addr_q, pend_addr_d;
  logic                pend_zero_q, pend_zero_d;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  logic [COL_W-1:0]    col_clamp, col_next;
  logic [ROW_W-1:0]    row_clamp, row_next;
  logic [LIN_W-1:0]    lin_clamp, lin_cur, lin_next;
  logic                last_col, last_row;

  always_comb begin
    col_clamp = (column_i > COL_MAX) ? COL_MAX : column_i;
    row_clamp = (row_i > ROW_MAX) ? ROW_MAX : row_i;
    last_col  = (col_q == COL_MAX);
    last_row  = (row_q == ROW_MAX);
    col_next  = last_col ? '0 : col_q + 1'b1;
    row_next  = (last_col && !last_row) ? row_q + 1'b1 : row_q;
    lin_clamp = lin_of(row_clamp, col_clamp);
    lin_cur   = lin_of(row_q, col_q);
    lin_next  = lin_of(row_next, col_next);
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    col_d       = col_q;
    row_d       = row_q;
    done_d      = 1'b0;
    cell_d      = '0;
    pos_d       = pos_q;
    scr_d       = 1'b0;
    pend_d      = 1'b0;
    pend_addr_d = idx_q;
    pend_zero_d = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = AW'(lin_clamp);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_e'(command_i))
            CMD_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(lin_cur);
              mem_wdata = {attr_q, character_i};
              col_d     = col_next;
              row_d     = row_next;
              done_d    = 1'b1;
              pos_d     = lin_next[POS_W-1:0];
              if (last_col && last_row) begin
                scr_d   = 1'b1;
                idx_d   = '0;
                state_d = ST_SCROLL;
              end
            end
            CMD_SET: begin
              col_d  = col_clamp;
              row_d  = row_clamp;
              done_d = 1'b1;
              pos_d  = lin_clamp[POS_W-1:0];
            end
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = ST_READ;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        cell_d  = mem_rdata;
        state_d = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row down, write back in the next cycle; last row fills with zero
        pend_d = 1'b1;
        if (idx_q < COPY_N) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_q + ROW_STEP;
          pend_zero_d = 1'b0;
        end
        if (idx_q == LAST_IDX) begin
          idx_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = pend_zero_q ? '0 : mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      attr_q  <= '0;
      done_q  <= 1'b0;
      pos_q   <= '0;
      scr_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      done_q  <= done_d;
      pos_q   <= pos_d;
      scr_q   <= scr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q      <= cell_d;
    pend_addr_q <= pend_addr_d;
    pend_zero_q <= pend_zero_d;
  end

  txc_cell_ram #(
    .DEPTH(CELLS),
    .AW   (AW)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign cell_word_o       = cell_q;
  assign cursor_position_o = pos_q;
  assign scrolled_o        = scr_q;

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_MAX) && (row_q <= ROW_MAX))
    else $error("cursor outside screen");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("result during clearing pass");

  a_scroll_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scrolled_o |-> done_o && (state_q == ST_SCROLL))
    else $error("scroll flag without scroll");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == CMD_READ)) |=> ##1 done_o)
    else $error("read result missing");
`endif

endmodule
`default_nettype wire

// ----- sv/txc_cell_ram.sv -----
// screen cell memory: one write port, one read port with registered data
`default_nettype none
module txc_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [txc_pkg::CELL_W-1:0]  wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [txc_pkg::CELL_W-1:0]  rdata_o
);
  import txc_pkg::*;

  logic [CELL_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- tb/text_console_writer_top_tb.sv -----
// self-checking testbench for the text console writer: directed and random commands
`default_nettype none
module text_console_writer_top_tb;
  import txc_pkg::*;

  localparam int unsigned COLUMNS        = 80;
  localparam int unsigned ROWS           = 25;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [POS_W-1:0]  pos;
    logic              scrolled;
  } console_word_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command_i   = '0;
  logic [CHAR_W-1:0]   character_i = '0;
  logic [COL_W-1:0]    column_i    = '0;
  logic [ROW_W-1:0]    row_i       = '0;
  logic                cfg_we_i    = 1'b0;
  logic [ATTR_W-1:0]   cfg_wdata_i = '0;
  logic                done_o;
  logic [CELL_W-1:0]   cell_word_o;
  logic [POS_W-1:0]    cursor_position_o;
  logic                scrolled_o;

  // predicted console state
  logic [CELL_W-1:0]   screen [ROWS*COLUMNS];
  int unsigned         cur_col;
  int unsigned         cur_row;
  logic [ATTR_W-1:0]   attr_reg;

  console_cmd_t        pending_q [$];
  console_word_t       expected_q [$];
  int unsigned         items_queued;
  int unsigned         mismatches;
  int unsigned         idle_cycles;
  int unsigned         gap_left;

  text_console_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .character_i      (character_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .cell_word_o      (cell_word_o),
    .cursor_position_o(cursor_position_o),
    .scrolled_o       (scrolled_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_col(input logic [COL_W-1:0] col);
    return (col > COLUMNS - 1) ? COLUMNS - 1 : int'(col);
  endfunction

  function automatic int unsigned clamp_row(input logic [ROW_W-1:0] row);
    return (row > ROWS - 1) ? ROWS - 1 : int'(row);
  endfunction

  // mostly short gaps, some stretches with none, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic apply_console_cmd(input console_cmd_t it);
    console_word_t res;
    int unsigned   c;
    int unsigned   r;
    res = '0;
    case (it.cmd)
      CMD_PUT: begin
        c = cur_col;
        r = cur_row;
        screen[r*COLUMNS + c] = {attr_reg, it.ch};
        c++;
        if (c >= COLUMNS) begin
          c = 0;
          if (r + 1 >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            for (int i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++) screen[i] = '0;
            res.scrolled = 1'b1;
          end else begin
            r++;
          end
        end
        cur_col = c;
        cur_row = r;
      end
      CMD_SET: begin
        cur_col = clamp_col(it.col);
        cur_row = clamp_row(it.row);
      end
      CMD_READ: begin
        res.cell_word = screen[clamp_row(it.row)*COLUMNS + clamp_col(it.col)];
      end
      default: begin
      end
    endcase
    res.pos = POS_W'(cur_row*COLUMNS + cur_col);
    expected_q.push_back(res);
  endtask

  task automatic add_item(input cmd_e cmd, input int unsigned ch, input int unsigned col,
                          input int unsigned row);
    console_cmd_t it;
    it.cmd = cmd;
    it.ch  = ch[CHAR_W-1:0];
    it.col = col[COL_W-1:0];
    it.row = row[ROW_W-1:0];
    pending_q.push_back(it);
    items_queued++;
  endtask

  task automatic add_random_items(input int unsigned count);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    int unsigned c;
    int unsigned r;
    target = items_queued + count;
    while (items_queued < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // write a short run of characters and read some of it back
        c = $urandom_range(0, COLUMNS - 1);
        r = $urandom_range(0, ROWS - 1);
        len = $urandom_range(1, 12);
        add_item(CMD_SET, $urandom, c, r);
        repeat (len) add_item(CMD_PUT, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 4)) add_item(CMD_READ, $urandom, c + $urandom_range(0, len), r);
      end else if (kind < 65) begin
        // run toward the bottom-right corner, which can cause a scroll
        add_item(CMD_SET, $urandom, $urandom_range(COLUMNS - 6, 127),
                 $urandom_range(ROWS - 2, 31));
        repeat ($urandom_range(1, 8)) add_item(CMD_PUT, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 4)) begin
          add_item(CMD_READ, $urandom, $urandom_range(0, 127), $urandom_range(ROWS - 3, ROWS - 1));
        end
      end else if (kind < 90) begin
        add_item(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      end else begin
        // long run of characters, which can cross row boundaries
        c = $urandom_range(0, COLUMNS - 1);
        r = $urandom_range(0, ROWS - 1);
        add_item(CMD_SET, $urandom, c, r);
        repeat ($urandom_range(20, 90)) add_item(CMD_PUT, $urandom, $urandom, $urandom);
        repeat ($urandom_range(2, 6)) begin
          add_item(CMD_READ, $urandom, $urandom_range(0, COLUMNS - 1), $urandom_range(0, ROWS - 1));
        end
      end
    end
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // driver: presents the head of the pending queue, holds it while busy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      command_i   <= CMD_NOP;
      character_i <= '0;
      column_i    <= '0;
      row_i       <= '0;
      gap_left     = 0;
    end else begin
      if (start && !busy) begin
        apply_console_cmd(pending_q[0]);
        pending_q.delete(0);
        gap_left = pick_gap();
      end
      if (start && busy) begin
        // word not taken yet, keep it on the ports
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        start       <= 1'b1;
        command_i   <= pending_q[0].cmd;
        character_i <= pending_q[0].ch;
        column_i    <= pending_q[0].col;
        row_i       <= pending_q[0].row;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each strobed result word against the oldest prediction
  always @(posedge clk_i) begin
    console_word_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: cell_word %h cursor_position %0d scrolled %0d",
               cell_word_o, cursor_position_o, scrolled_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (cell_word_o !== want.cell_word) begin
          $error("cell_word expected %h actual %h", want.cell_word, cell_word_o);
          mismatches++;
        end
        if (cursor_position_o !== want.pos) begin
          $error("cursor_position expected %0d actual %0d", want.pos, cursor_position_o);
          mismatches++;
        end
        if (scrolled_o !== want.scrolled) begin
          $error("scrolled expected %0d actual %0d", want.scrolled, scrolled_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles in which no command and no result is taken
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [ATTR_W-1:0] attr_val;
    foreach (screen[i]) screen[i] = '0;
    cur_col      = 0;
    cur_row      = 0;
    attr_reg     = '0;
    items_queued = 0;
    mismatches   = 0;
    idle_cycles  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every command, clamping, scroll, row wrap
    add_item(CMD_PUT,  8'h00, 0, 0);
    add_item(CMD_PUT,  8'hFF, 127, 31);
    add_item(CMD_PUT,  8'h80, 0, 0);
    add_item(CMD_READ, 8'h00, 0, 0);
    add_item(CMD_READ, 8'hFF, 1, 0);
    add_item(CMD_READ, 8'h00, 2, 0);
    add_item(CMD_SET,  8'h00, 127, 31);
    add_item(CMD_READ, 8'h00, 127, 31);
    add_item(CMD_PUT,  8'h7F, 0, 0);
    add_item(CMD_READ, 8'h00, COLUMNS - 1, ROWS - 2);
    add_item(CMD_READ, 8'h00, 0, 0);
    add_item(CMD_NOP,  8'hFF, 127, 31);
    add_item(CMD_SET,  8'h00, COLUMNS - 2, 0);
    add_item(CMD_PUT,  8'h55, 0, 0);
    add_item(CMD_PUT,  8'hAA, 0, 0);
    add_item(CMD_READ, 8'h00, COLUMNS - 1, 0);
    add_item(CMD_SET,  8'h00, COLUMNS, 3);
    add_item(CMD_SET,  8'h00, 5, ROWS);
    add_item(CMD_READ, 8'h00, COLUMNS - 1, ROWS);
    add_item(CMD_SET,  8'h00, 0, 0);
    add_item(CMD_NOP,  8'h00, 0, 0);

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0:       attr_val = 8'hFF;
        1:       attr_val = 8'h00;
        4:       attr_val = 8'h0F;
        default: attr_val = ATTR_W'($urandom_range(1, 254));
      endcase
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= attr_val;
      attr_reg     = attr_val;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      @(negedge clk_i);
      add_random_items(200);
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- text_console_writer_top.f -----
sv/txc_pkg.sv
sv/txc_cell_ram.sv
sv/text_console_writer_top.sv
tb/text_console_writer_top_tb.sv
